// ===== hdl/block_rms_meter_defines.svh =====
// Assertion macros for the checker of the RMS meter.
`ifndef BLOCK_RMS_METER_DEFINES_SVH
`define BLOCK_RMS_METER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define BRM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("block_rms_meter: assertion failed");

// Next-cycle implication, held off during reset.
`define BRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("block_rms_meter: assertion failed");

`endif

// ===== hdl/brm_pkg.sv =====
`default_nettype none

package brm_pkg;

  // Fixed formats of the ports.
  localparam int SAMPLE_W  = 16;
  localparam int RMS_W     = 24;
  localparam int OUT_CNT_W = 11;

  // Block format.
  localparam int MAX_SAMPLES   = 1024;
  localparam int FRACTION_BITS = 8;

  // Derived datapath widths.
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SQ_W    = 2 * SAMPLE_W - 1;
  localparam int SUM_W   = SQ_W + CNT_W - 1;
  localparam int SHIFT   = 2 * FRACTION_BITS;
  localparam int NUM_W   = SUM_W + SHIFT;
  localparam int MEAN_W  = SQ_W + SHIFT;
  localparam int RAD_W   = MEAN_W + (MEAN_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int STEP_W  = $clog2(NUM_W);

  // Largest possible result: a full-scale negative sample every time.
  localparam int RMS_MAX = 1 << (SAMPLE_W - 1 + FRACTION_BITS);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_FLUSH,
    ST_DIV_INIT,
    ST_DIVIDE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_PUBLISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_init;
    logic div_step;
    logic root_init;
    logic root_step;
    logic publish;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== hdl/brm_ctrl.sv =====
`default_nettype none

module brm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              last_sample,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output brm_pkg::dp_cmd_t  cmd
);

  localparam logic [brm_pkg::STEP_W-1:0] DIV_LAST  = brm_pkg::STEP_W'(brm_pkg::NUM_W - 1);
  localparam logic [brm_pkg::STEP_W-1:0] ROOT_LAST = brm_pkg::STEP_W'(brm_pkg::ROOT_W - 1);

  brm_pkg::state_t           state, state_next;
  logic [brm_pkg::STEP_W-1:0] step, step_next;
  logic                       out_valid_next;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brm_pkg::ST_ACCUM;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      brm_pkg::ST_ACCUM:     if (in_valid && last_sample) state_next = brm_pkg::ST_FLUSH;
      brm_pkg::ST_FLUSH:     state_next = brm_pkg::ST_DIV_INIT;
      brm_pkg::ST_DIV_INIT:  state_next = brm_pkg::ST_DIVIDE;
      brm_pkg::ST_DIVIDE:    if (step == DIV_LAST) state_next = brm_pkg::ST_ROOT_INIT;
      brm_pkg::ST_ROOT_INIT: state_next = brm_pkg::ST_ROOT;
      brm_pkg::ST_ROOT:      if (step == ROOT_LAST) state_next = brm_pkg::ST_PUBLISH;
      brm_pkg::ST_PUBLISH:   if (out_free) state_next = brm_pkg::ST_ACCUM;
      default:               state_next = brm_pkg::ST_ACCUM;
    endcase
  end

  // Iteration counter for the divider and the root.
  always_comb begin
    step_next = '0;
    if ((state == brm_pkg::ST_DIVIDE && step != DIV_LAST) ||
        (state == brm_pkg::ST_ROOT && step != ROOT_LAST)) begin
      step_next = step + 1'b1;
    end
  end

  // Outputs and commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state)
      brm_pkg::ST_ACCUM: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      brm_pkg::ST_FLUSH:     cmd = '0;
      brm_pkg::ST_DIV_INIT:  cmd.div_init  = 1'b1;
      brm_pkg::ST_DIVIDE:    cmd.div_step  = 1'b1;
      brm_pkg::ST_ROOT_INIT: cmd.root_init = 1'b1;
      brm_pkg::ST_ROOT:      cmd.root_step = 1'b1;
      brm_pkg::ST_PUBLISH:   cmd.publish   = out_free;
      default:               cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.publish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/brm_datapath.sv =====
`default_nettype none

module brm_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  brm_pkg::dp_cmd_t                    cmd,
  input  logic signed [brm_pkg::SAMPLE_W-1:0] sample,
  output logic [brm_pkg::RMS_W-1:0]           rms_value,
  output logic [brm_pkg::OUT_CNT_W-1:0]       sample_count,
  output logic                                overflowed
);

  // Accumulator.
  logic signed [2*brm_pkg::SAMPLE_W-1:0] prod;
  logic [brm_pkg::SQ_W-1:0]              sq;
  logic                                  sq_vld;
  logic [brm_pkg::SUM_W-1:0]             sum;
  logic [brm_pkg::CNT_W-1:0]             count;
  logic                                  dropped;
  logic                                  room;

  // Divider: remainder and a numerator that turns into the quotient.
  logic [brm_pkg::CNT_W-1:0]             rem;
  logic [brm_pkg::NUM_W-1:0]             num;
  logic [brm_pkg::CNT_W:0]               trial;
  logic                                  fits;

  // Square root.
  logic [brm_pkg::RAD_W-1:0]             rad;
  logic [brm_pkg::RAD_W-1:0]             root;
  logic [brm_pkg::RAD_W-1:0]             rbit;
  logic [brm_pkg::RAD_W-1:0]             rtrial;

  assign prod  = sample * sample;
  assign room  = count < brm_pkg::CNT_W'(brm_pkg::MAX_SAMPLES);
  assign trial = {rem, num[brm_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, count};
  // The trial bit always sits below the lowest set bit of root.
  assign rtrial = root | rbit;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld  <= 1'b0;
      sum     <= '0;
      count   <= '0;
      dropped <= 1'b0;
    end else begin
      sq_vld <= cmd.accept && room;
      if (cmd.publish) begin
        sum     <= '0;
        count   <= '0;
        dropped <= 1'b0;
      end else begin
        if (sq_vld) begin
          sum <= sum + brm_pkg::SUM_W'(sq);
        end
        if (cmd.accept) begin
          if (room) begin
            count <= count + 1'b1;
          end else begin
            dropped <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq <= prod[brm_pkg::SQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= '0;
      num <= brm_pkg::NUM_W'(sum) << brm_pkg::SHIFT;
    end else if (cmd.div_step) begin
      rem <= fits ? brm_pkg::CNT_W'(trial - {1'b0, count}) : brm_pkg::CNT_W'(trial);
      num <= {num[brm_pkg::NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad  <= (count == '0) ? '0 : brm_pkg::RAD_W'(num[brm_pkg::MEAN_W-1:0]);
      root <= '0;
      rbit <= brm_pkg::RAD_W'(1) << (brm_pkg::RAD_W - 2);
    end else if (cmd.root_step) begin
      if (rad >= rtrial) begin
        rad  <= rad - rtrial;
        root <= (root >> 1) | rbit;
      end else begin
        root <= root >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      rms_value    <= brm_pkg::RMS_W'(root);
      sample_count <= brm_pkg::OUT_CNT_W'(count);
      overflowed   <= dropped;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/block_rms_meter.sv =====
// Channel  Handshake               Payload
// input    in_valid / in_ready     sample, last_sample
// output   out_valid / out_ready   rms_value, sample_count, overflowed
//
// While a block is open, one sample is taken every cycle.
// After the closing sample the block flushes the squaring stage and runs
// the bit-serial divider and square root, during which in_ready is low.
// The result sits in an output register, so the next block starts
// accumulating while a finished result still waits to be taken.
// Reset is synchronous and clears the sums, the count and the valid flag.
`default_nettype none

module block_rms_meter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [brm_pkg::SAMPLE_W-1:0] sample,
  input  logic                                last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [brm_pkg::RMS_W-1:0]           rms_value,
  output logic [brm_pkg::OUT_CNT_W-1:0]       sample_count,
  output logic                                overflowed
);

  // Commands from the sequencer to the datapath.
  brm_pkg::dp_cmd_t cmd;

  // The controller steps through accumulate, a flush of the squaring
  // stage, the restoring divide, the square root and publish.
  brm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .last_sample (last_sample),
    .out_ready   (out_ready),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .cmd         (cmd)
  );

  // The datapath squares each sample in the cycle it arrives, adds the
  // square in the next cycle, then reuses its registers for the mean and
  // the root, one result bit per cycle.
  brm_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sample       (sample),
    .rms_value    (rms_value),
    .sample_count (sample_count),
    .overflowed   (overflowed)
  );

endmodule

`default_nettype wire

// ===== hdl/brm_checker.sv =====
`default_nettype none

`include "block_rms_meter_defines.svh"

module brm_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [brm_pkg::SAMPLE_W-1:0] sample,
  input logic                                last_sample,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [brm_pkg::RMS_W-1:0]           rms_value,
  input logic [brm_pkg::OUT_CNT_W-1:0]       sample_count,
  input logic                                overflowed
);

  `BRM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(rms_value))
  `BRM_ASSERT_NOW(a_count_nonzero, out_valid, sample_count != '0)
  `BRM_ASSERT_NOW(a_drop_full, out_valid && overflowed,
                  sample_count == brm_pkg::OUT_CNT_W'(brm_pkg::MAX_SAMPLES))
  `BRM_ASSERT_NOW(a_rms_range, out_valid, rms_value <= brm_pkg::RMS_W'(brm_pkg::RMS_MAX))
  `BRM_ASSERT_NEXT(a_close_busy, in_valid && in_ready && last_sample, !in_ready)

endmodule

bind block_rms_meter brm_checker u_brm_checker (.*);

`default_nettype wire
